/* hw/rtl/pmct_pkg.sv */
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types and constants for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

    // Field widths fixed by the external format
    localparam int BYTE_W      = 8;
    localparam int BOUND_W     = 13;
    localparam int OUT_COORD_W = 12;
    localparam int BTN_W       = 3;

    // Default coordinate register width
    localparam int COORD_BITS_DEFAULT = 12;

    // Bound registers after reset
    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd768;

    // Configuration register indexes
    localparam logic CFG_WIDTH_BOUND  = 1'b0;
    localparam logic CFG_HEIGHT_BOUND = 1'b1;

    // First-byte flag masks
    localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] SYNC_MASK     = 8'h08;
    localparam logic [BYTE_W-1:0] BUTTON_MASK   = 8'h07;

    // Speed-up threshold on |dx|+|dy|
    localparam int ACCEL_LIMIT = 8;

    // One assembled three-byte packet
    typedef struct packed {
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
    } t_packet;

    // Configuration write request
    typedef struct packed {
        logic               we;
        logic               idx;
        logic [BOUND_W-1:0] data;
    } t_cfg_write;

endpackage

/* hw/rtl/pmct_byte_if.sv */
// ----------------------------------------------------------------------------
// pmct_byte_if
// Byte stream channel from the PS/2 receiver: valid, ready, one raw byte.
// ----------------------------------------------------------------------------
interface pmct_byte_if;
    import pmct_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

/* hw/rtl/pmct_cursor_if.sv */
// ----------------------------------------------------------------------------
// pmct_cursor_if
// Cursor result channel: valid, ready, position and button state.
// ----------------------------------------------------------------------------
interface pmct_cursor_if;
    import pmct_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OUT_COORD_W-1:0] cursor_x;
    logic [OUT_COORD_W-1:0] cursor_y;
    logic [BTN_W-1:0]       buttons;

    modport source (output valid, output cursor_x, output cursor_y, output buttons,
                    input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                    output ready);
endinterface

/* hw/rtl/pmct_assembler.sv */
// ----------------------------------------------------------------------------
// pmct_assembler
// Groups incoming bytes into three-byte packets held in a packet register.
// ----------------------------------------------------------------------------
module pmct_assembler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    output logic              o_byte_ready,
    input  logic [pmct_pkg::BYTE_W-1:0] i_raw_byte,
    output logic              o_pkt_valid,
    input  logic              i_pkt_ready,
    output pmct_pkg::t_packet o_pkt
);
    import pmct_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0]        r_phase;
    logic [1:0]        n_phase;
    logic [BYTE_W-1:0] r_hold [2];
    logic              r_pkt_valid;
    logic              n_pkt_valid;
    t_packet           r_pkt;
    logic              byte_take;
    logic              pkt_take;
    logic              pkt_done;

    // Accept a byte unless a finished packet is stuck
    assign pkt_take     = r_pkt_valid && i_pkt_ready;
    assign o_byte_ready = !r_pkt_valid || i_pkt_ready;
    assign byte_take    = i_byte_valid && o_byte_ready;
    assign pkt_done     = byte_take && (r_phase == PH_THIRD);

    // Advance the byte phase
    always_comb begin
        n_phase = r_phase;
        if (byte_take) begin
            case (r_phase)
                PH_FIRST:  n_phase = PH_SECOND;
                PH_SECOND: n_phase = PH_THIRD;
                default:   n_phase = PH_FIRST;
            endcase
        end
    end

    // Hold the packet until the motion stage takes it
    always_comb begin
        n_pkt_valid = r_pkt_valid;
        if (pkt_take) begin
            n_pkt_valid = 1'b0;
        end
        if (pkt_done) begin
            n_pkt_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_pkt_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pkt_valid <= n_pkt_valid;
        end
    end

    // Store the first two bytes and launch the packet on the third
    always_ff @(posedge i_clk) begin
        if (byte_take && r_phase == PH_FIRST) begin
            r_hold[0] <= i_raw_byte;
        end
        if (byte_take && r_phase == PH_SECOND) begin
            r_hold[1] <= i_raw_byte;
        end
        if (pkt_done) begin
            r_pkt.flags <= r_hold[0];
            r_pkt.dx    <= r_hold[1];
            r_pkt.dy    <= i_raw_byte;
        end
    end

    assign o_pkt_valid = r_pkt_valid;
    assign o_pkt       = r_pkt;
endmodule

/* hw/rtl/pmct_motion.sv */
// ----------------------------------------------------------------------------
// pmct_motion
// Checks a packet, moves and clamps the cursor, and registers the result.
// ----------------------------------------------------------------------------
module pmct_motion #(
    parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmct_pkg::t_cfg_write i_cfg,
    input  logic                 i_pkt_valid,
    output logic                 o_pkt_ready,
    input  pmct_pkg::t_packet    i_pkt,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [pmct_pkg::OUT_COORD_W-1:0] o_cursor_x,
    output logic [pmct_pkg::OUT_COORD_W-1:0] o_cursor_y,
    output logic [pmct_pkg::BTN_W-1:0]       o_buttons
);
    import pmct_pkg::*;

    // Wide enough for the bound register, 2^COORD_BITS and position +/- 256
    localparam int BASE_W = (COORD_BITS + 1 > BOUND_W) ? COORD_BITS + 1 : BOUND_W;
    localparam int CALC_W = BASE_W + 2;
    localparam logic [CALC_W-1:0] SPAN = CALC_W'(1) << COORD_BITS;

    // Clip a bound register to [1, 2^COORD_BITS]
    function automatic logic [CALC_W-1:0] eff_bound(input logic [BOUND_W-1:0] bound);
        logic [CALC_W-1:0] b;
        b = CALC_W'(bound);
        if (b == '0) begin
            b = CALC_W'(1);
        end
        if (b > SPAN) begin
            b = SPAN;
        end
        return b;
    endfunction

    // Clamp a moved coordinate into [0, bound-1]
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [CALC_W-1:0] v,
        input logic [BOUND_W-1:0]       bound
    );
        logic [CALC_W-1:0] b;
        logic [CALC_W-1:0] r;
        b = eff_bound(bound);
        if (v < 0) begin
            r = '0;
        end else if ($unsigned(v) >= b) begin
            r = b - CALC_W'(1);
        end else begin
            r = $unsigned(v);
        end
        return r[COORD_BITS-1:0];
    endfunction

    localparam logic [COORD_BITS-1:0] POS_X_RESET =
        COORD_BITS'(eff_bound(WIDTH_RESET) >> 1);
    localparam logic [COORD_BITS-1:0] POS_Y_RESET =
        COORD_BITS'(eff_bound(HEIGHT_RESET) >> 1);

    logic [BOUND_W-1:0]     r_width_bound;
    logic [BOUND_W-1:0]     r_height_bound;
    logic [COORD_BITS-1:0]  r_pos_x;
    logic [COORD_BITS-1:0]  r_pos_y;
    logic                   r_res_valid;
    logic [OUT_COORD_W-1:0] r_cursor_x;
    logic [OUT_COORD_W-1:0] r_cursor_y;
    logic [BTN_W-1:0]       r_buttons;

    logic                     pkt_take;
    logic                     pkt_good;
    logic signed [CALC_W-1:0] dx_raw;
    logic signed [CALC_W-1:0] dy_raw;
    logic [CALC_W-1:0]        mag;
    logic signed [CALC_W-1:0] dx_s;
    logic signed [CALC_W-1:0] dy_s;
    logic signed [CALC_W-1:0] sum_x;
    logic signed [CALC_W-1:0] sum_y;
    logic [COORD_BITS-1:0]    n_pos_x;
    logic [COORD_BITS-1:0]    n_pos_y;
    logic [CALC_W-1:0]        ext_x;
    logic [CALC_W-1:0]        ext_y;

    // Take a packet whenever the result register is free or draining
    assign o_pkt_ready = !r_res_valid || i_res_ready;
    assign pkt_take    = i_pkt_valid && o_pkt_ready;
    assign pkt_good    = ((i_pkt.flags & OVERFLOW_MASK) == '0)
                      && ((i_pkt.flags & SYNC_MASK) != '0);

    // Deltas: y negated, doubled above the speed-up threshold
    always_comb begin
        dx_raw = CALC_W'($signed(i_pkt.dx));
        dy_raw = -CALC_W'($signed(i_pkt.dy));
        mag    = $unsigned(dx_raw < 0 ? -dx_raw : dx_raw)
               + $unsigned(dy_raw < 0 ? -dy_raw : dy_raw);
        if (mag > CALC_W'(ACCEL_LIMIT)) begin
            dx_s = dx_raw <<< 1;
            dy_s = dy_raw <<< 1;
        end else begin
            dx_s = dx_raw;
            dy_s = dy_raw;
        end
        sum_x   = $signed(CALC_W'(r_pos_x)) + dx_s;
        sum_y   = $signed(CALC_W'(r_pos_y)) + dy_s;
        n_pos_x = clamp_coord(sum_x, r_width_bound);
        n_pos_y = clamp_coord(sum_y, r_height_bound);
        ext_x   = CALC_W'(n_pos_x);
        ext_y   = CALC_W'(n_pos_y);
    end

    // Bounds, position and result valid; a bound write recentres its axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_bound  <= WIDTH_RESET;
            r_height_bound <= HEIGHT_RESET;
            r_pos_x        <= POS_X_RESET;
            r_pos_y        <= POS_Y_RESET;
            r_res_valid    <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_WIDTH_BOUND: begin
                        r_width_bound <= i_cfg.data;
                        r_pos_x       <= COORD_BITS'(eff_bound(i_cfg.data) >> 1);
                    end
                    CFG_HEIGHT_BOUND: begin
                        r_height_bound <= i_cfg.data;
                        r_pos_y        <= COORD_BITS'(eff_bound(i_cfg.data) >> 1);
                    end
                    default: begin
                    end
                endcase
            end else if (pkt_take && pkt_good) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_res_valid <= 1'b1;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (pkt_take && pkt_good) begin
            r_cursor_x <= ext_x[OUT_COORD_W-1:0];
            r_cursor_y <= ext_y[OUT_COORD_W-1:0];
            r_buttons  <= BTN_W'(i_pkt.flags & BUTTON_MASK);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;
    assign o_buttons   = r_buttons;
endmodule

/* hw/rtl/ps2_mouse_cursor_tracker.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Decodes three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless the cursor output stalls, set by the
//   single packet register between the byte assembler and the motion stage.
// Path: the third byte fills the packet register, then the result register.
// Reset: byte phase cleared, bounds 1024 x 768, cursor at the bound centres,
//   no result pending. Packets with overflow set or no sync bit give no result.
module ps2_mouse_cursor_tracker #(
    parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pmct_byte_if.sink                    i_byte,
    pmct_cursor_if.source                o_cursor,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [pmct_pkg::BOUND_W-1:0] i_cfg_data
);
    import pmct_pkg::*;

    t_cfg_write cfg;
    t_packet    pkt;
    logic       pkt_valid;
    logic       pkt_ready;

    // Bundle the configuration write
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    pmct_assembler u_assembler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_byte.valid),
        .o_byte_ready (i_byte.ready),
        .i_raw_byte   (i_byte.raw_byte),
        .o_pkt_valid  (pkt_valid),
        .i_pkt_ready  (pkt_ready),
        .o_pkt        (pkt)
    );

    pmct_motion #(
        .COORD_BITS (COORD_BITS)
    ) u_motion (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pkt_valid (pkt_valid),
        .o_pkt_ready (pkt_ready),
        .i_pkt       (pkt),
        .o_res_valid (o_cursor.valid),
        .i_res_ready (o_cursor.ready),
        .o_cursor_x  (o_cursor.cursor_x),
        .o_cursor_y  (o_cursor.cursor_y),
        .o_buttons   (o_cursor.buttons)
    );
endmodule
